### rtl/weekly_alarm_table_matcher_assert.svh
// Assertion macros for the weekly alarm table matcher.
// Used by the top level; the macros expect signals named clk and rst_n in scope.
`ifndef WEEKLY_ALARM_TABLE_MATCHER_ASSERT_SVH
`define WEEKLY_ALARM_TABLE_MATCHER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WATM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WATM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/watm_pkg.sv
// Shared types and constants of the weekly alarm table matcher.
// No dependencies; the matcher top level and the cell import this package.
`default_nettype none

package watm_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 8;

  // Epochs below this value mean the real-time clock has not been set.
  localparam logic [31:0] SYNC_EPOCH_MIN = 32'd1000000000;

  // floor(x / 60) == (x * DIV60_MAGIC) >> DIV60_SHIFT for every 32-bit x.
  localparam logic [31:0] DIV60_MAGIC = 32'h8888_8889;
  localparam int          DIV60_SHIFT = 37;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_UPDATE = 2'd2;
  localparam logic [1:0] FUNC_CHECK  = 2'd3;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_FIRE   = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  typedef struct packed {
    logic        en;
    logic [4:0]  hr;
    logic [5:0]  mn;
    logic [6:0]  days;
    logic [2:0]  pump;
    logic [15:0] dose;
  } entry_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic wr;
    logic shift;
    logic match;
    logic live;
  } cell_ctl_t;

  // Data broadcast to every cell of the row.
  typedef struct packed {
    entry_t      entry;
    logic [31:0] emin;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [2:0]  weekday;
  } bcast_t;

endpackage

`default_nettype wire

### rtl/watm_if.sv
// Valid/ready stream interfaces for the item and result channels.
// Depends on nothing but the field widths of the block.
`default_nettype none

interface watm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [2:0]  slot_index;
  logic        entry_enabled;
  logic [4:0]  entry_hour;
  logic [5:0]  entry_minute;
  logic [6:0]  entry_day_mask;
  logic [2:0]  entry_pump;
  logic [15:0] entry_dose;
  logic [31:0] epoch_seconds;
  logic [4:0]  now_hour;
  logic [5:0]  now_minute;
  logic [2:0]  now_weekday;

  modport source (
    output valid, func, slot_index, entry_enabled, entry_hour, entry_minute,
           entry_day_mask, entry_pump, entry_dose, epoch_seconds, now_hour,
           now_minute, now_weekday,
    input  ready
  );
  modport sink (
    input  valid, func, slot_index, entry_enabled, entry_hour, entry_minute,
           entry_day_mask, entry_pump, entry_dose, epoch_seconds, now_hour,
           now_minute, now_weekday,
    output ready
  );
endinterface

interface watm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        ok;
  logic [2:0]  fired_slot;
  logic [2:0]  fire_pump;
  logic [15:0] fire_dose;
  logic [3:0]  entry_count;
  logic        clock_synced;
  logic        last;

  modport source (
    output valid, kind, ok, fired_slot, fire_pump, fire_dose, entry_count,
           clock_synced, last,
    input  ready
  );
  modport sink (
    input  valid, kind, ok, fired_slot, fire_pump, fire_dose, entry_count,
           clock_synced, last,
    output ready
  );
endinterface

`default_nettype wire

### rtl/weekly_alarm_table_matcher.sv
// Weekly alarm table matcher: one item at a time through a small sequencer.
// An add, remove or update passes through the execute and finish states and has
// its status result registered in the finish state. A check with the clock set
// also passes through the match and scan states before its closing result; a
// check with the clock not set goes from execute straight to the finish state.
// The epoch minute comes from one registered 32x32 reciprocal multiply, every
// cell then compares in parallel, and a scan counter walks the cells, one per
// cycle while no fire request waits on a full output register, to emit fire
// requests in slot order before the closing result. A remove shifts all later
// cells down together. Results stall the scan while the output register is full;
// the next item is accepted once the final result is registered.
`default_nettype none

module weekly_alarm_table_matcher #(
  parameter int TABLE_DEPTH = watm_pkg::DEFAULT_TABLE_DEPTH
) (
  input logic         clk,
  input logic         rst_n,
  watm_in_if.sink     in_ch,
  watm_out_if.source  out_ch
);
  import watm_pkg::*;

  `include "weekly_alarm_table_matcher_assert.svh"

  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CMPW = (CW > 3) ? CW : 3;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_MATCH = 5'b00100,
    S_SCAN  = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  slot;
    entry_t      entry;
    logic [31:0] epoch;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [2:0]  weekday;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [2:0]  slot;
    logic [2:0]  pump;
    logic [15:0] dose;
    logic [3:0]  count;
    logic        synced;
    logic        last;
  } result_t;

  state_t          state_r, state_nxt;
  item_t           item_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   scan_r, scan_nxt;
  logic            synced_r, synced_nxt;
  logic            ok_r, ok_nxt;
  logic [63:0]     prod_r;
  logic            out_valid_r, out_valid_nxt;
  result_t         out_r, out_nxt;

  logic            slot_free;
  logic            in_take;
  logic            slot_in_use;
  logic            op_ok;
  logic            exec_op;
  bcast_t          bc;
  cell_ctl_t       ctl  [TABLE_DEPTH];
  entry_t          ent  [TABLE_DEPTH];
  logic [31:0]     lfm  [TABLE_DEPTH];
  logic            hits [TABLE_DEPTH];
  logic [IW-1:0]   scan_idx;

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign scan_idx    = scan_r[IW-1:0];
  assign slot_in_use = CMPW'(item_r.slot) < CMPW'(count_r);

  always_comb begin
    case (item_r.func)
      FUNC_ADD:    op_ok = count_r < CW'(TABLE_DEPTH);
      FUNC_REMOVE: op_ok = slot_in_use;
      FUNC_UPDATE: op_ok = slot_in_use;
      default:     op_ok = 1'b0;
    endcase
  end

  assign exec_op = (state_r == S_EXEC) && op_ok;

  assign bc.entry   = item_r.entry;
  assign bc.emin    = 32'(prod_r[63:DIV60_SHIFT]);
  assign bc.hour    = item_r.hour;
  assign bc.minute  = item_r.minute;
  assign bc.weekday = item_r.weekday;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign ctl[i].wr = exec_op &&
        (((item_r.func == FUNC_ADD) && (count_r == CW'(i))) ||
         ((item_r.func == FUNC_UPDATE) && (CMPW'(item_r.slot) == CMPW'(i))));
    assign ctl[i].shift = exec_op && (item_r.func == FUNC_REMOVE) &&
        (CMPW'(i) >= CMPW'(item_r.slot)) && (CMPW'(i + 1) < CMPW'(count_r));
    assign ctl[i].match = (state_r == S_MATCH);
    assign ctl[i].live  = CMPW'(i) < CMPW'(count_r);

    if (i + 1 < TABLE_DEPTH) begin : g_mid
      watm_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl[i]),
        .bc       (bc),
        .nb_entry (ent[i+1]),
        .nb_lfm   (lfm[i+1]),
        .entry    (ent[i]),
        .lfm      (lfm[i]),
        .hit      (hits[i])
      );
    end else begin : g_end
      // The last cell never takes from a neighbour; it is fed back to itself.
      watm_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl[i]),
        .bc       (bc),
        .nb_entry (ent[i]),
        .nb_lfm   (lfm[i]),
        .entry    (ent[i]),
        .lfm      (lfm[i]),
        .hit      (hits[i])
      );
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    synced_nxt    = synced_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (item_r.func == FUNC_CHECK) begin
          if (item_r.epoch < SYNC_EPOCH_MIN) begin
            synced_nxt = 1'b0;
            state_nxt  = S_FIN;
          end else begin
            synced_nxt = 1'b1;
            state_nxt  = S_MATCH;
          end
        end else begin
          ok_nxt    = op_ok;
          state_nxt = S_FIN;
          if (op_ok && (item_r.func == FUNC_ADD)) begin
            count_nxt = count_r + CW'(1);
          end else if (op_ok && (item_r.func == FUNC_REMOVE)) begin
            count_nxt = count_r - CW'(1);
          end
        end
      end
      S_MATCH: begin
        scan_nxt  = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_r == count_r) begin
          state_nxt = S_FIN;
        end else if (!hits[scan_idx]) begin
          scan_nxt = scan_r + CW'(1);
        end else if (slot_free) begin
          scan_nxt      = scan_r + CW'(1);
          out_valid_nxt = 1'b1;
          out_nxt.kind   = KIND_FIRE;
          out_nxt.ok     = 1'b1;
          out_nxt.slot   = 3'(scan_r);
          out_nxt.pump   = ent[scan_idx].pump;
          out_nxt.dose   = ent[scan_idx].dose;
          out_nxt.count  = 4'(count_r);
          out_nxt.synced = synced_r;
          out_nxt.last   = 1'b0;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_nxt.kind   = (item_r.func == FUNC_CHECK) ? KIND_DONE : KIND_STATUS;
          out_nxt.ok     = (item_r.func == FUNC_CHECK) ? 1'b1 : ok_r;
          out_nxt.slot   = '0;
          out_nxt.pump   = '0;
          out_nxt.dose   = '0;
          out_nxt.count  = 4'(count_r);
          out_nxt.synced = synced_r;
          out_nxt.last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      synced_r    <= 1'b0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      synced_r    <= synced_nxt;
      ok_r        <= ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: item capture, epoch-minute product and the result slot.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.func          <= in_ch.func;
      item_r.slot          <= in_ch.slot_index;
      item_r.entry.en      <= in_ch.entry_enabled;
      item_r.entry.hr      <= in_ch.entry_hour;
      item_r.entry.mn      <= in_ch.entry_minute;
      item_r.entry.days    <= in_ch.entry_day_mask;
      item_r.entry.pump    <= in_ch.entry_pump;
      item_r.entry.dose    <= in_ch.entry_dose;
      item_r.epoch         <= in_ch.epoch_seconds;
      item_r.hour          <= in_ch.now_hour;
      item_r.minute        <= in_ch.now_minute;
      item_r.weekday       <= in_ch.now_weekday;
    end
    if (state_r == S_EXEC) begin
      prod_r <= 64'(item_r.epoch) * 64'(DIV60_MAGIC);
    end
    out_r <= out_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_r.kind;
  assign out_ch.ok           = out_r.ok;
  assign out_ch.fired_slot   = out_r.slot;
  assign out_ch.fire_pump    = out_r.pump;
  assign out_ch.fire_dose    = out_r.dose;
  assign out_ch.entry_count  = out_r.count;
  assign out_ch.clock_synced = out_r.synced;
  assign out_ch.last         = out_r.last;

  `WATM_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(TABLE_DEPTH), "table count above depth")
  `WATM_ASSERT_NOW(a_scan_bound, state_r == S_SCAN, scan_r <= count_r, "scan ran past the count")
  `WATM_ASSERT_NOW(a_fire_synced, out_valid_r && (out_r.kind == KIND_FIRE), synced_r, "fire while unsynced")
  `WATM_ASSERT_NEXT(a_take_exec, in_take, state_r == S_EXEC, "accepted transaction not executed")
  `WATM_ASSERT_NEXT(a_fire_not_last, (state_r == S_SCAN) && (state_nxt == S_SCAN) && out_valid_nxt && !out_valid_r, !out_r.last, "fire request marked last")

endmodule

`default_nettype wire

### rtl/watm_cell.sv
// One cell of the alarm table row: an entry, its last fired minute and a hit flag.
// Depends on watm_pkg.
`default_nettype none

module watm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  watm_pkg::cell_ctl_t ctl,
  input  watm_pkg::bcast_t    bc,
  input  watm_pkg::entry_t    nb_entry,
  input  logic [31:0]         nb_lfm,
  output watm_pkg::entry_t    entry,
  output logic [31:0]         lfm,
  output logic                hit
);
  import watm_pkg::*;

  entry_t      entry_r;
  logic [31:0] lfm_r;
  logic        hit_r;
  logic [7:0]  day_ext;
  logic        fire;

  // A weekday of seven selects the padding bit and so never matches.
  assign day_ext = {1'b0, entry_r.days};

  assign fire = ctl.live && entry_r.en && (entry_r.hr == bc.hour) &&
                (entry_r.mn == bc.minute) && (lfm_r != bc.emin) &&
                day_ext[bc.weekday];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      entry_r <= bc.entry;
    end else if (ctl.shift) begin
      entry_r <= nb_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfm_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (ctl.wr) begin
        lfm_r <= '0;
      end else if (ctl.shift) begin
        lfm_r <= nb_lfm;
      end else if (ctl.match && fire) begin
        lfm_r <= bc.emin;
      end
      if (ctl.match) begin
        hit_r <= fire;
      end
    end
  end

  assign entry = entry_r;
  assign lfm   = lfm_r;
  assign hit   = hit_r;

endmodule

`default_nettype wire
